### rtl/lsba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsba_pkg;

  // Default segment table depth
  localparam int unsigned MaxSegmentsDefault = 256;

  // Divider operand widths: overhead plus payload, and bytes per block
  localparam int unsigned DivW  = 33;
  localparam int unsigned DvsrW = 17;

  // Largest segment in blocks
  localparam logic [16:0] SegSizeMax = 17'd65536;

  // Register indexes (byte address / 4)
  localparam logic [2:0] RegSegmentTotal  = 3'd0;
  localparam logic [2:0] RegSegmentBlocks = 3'd1;
  localparam logic [2:0] RegReserved      = 3'd2;
  localparam logic [2:0] RegBlockBytes    = 3'd3;
  localparam logic [2:0] RegOverhead      = 3'd4;

  // Register reset values
  localparam logic [8:0]  SegmentTotalRst  = 9'd256;
  localparam logic [16:0] SegmentBlocksRst = 17'd1024;
  localparam logic [15:0] ReservedRst      = 16'd1;
  localparam logic [16:0] BlockBytesRst    = 17'd4096;
  localparam logic [12:0] OverheadRst      = 13'd0;

  typedef enum logic [1:0] {
    FuncAlloc  = 2'd0,
    FuncNote   = 2'd1,
    FuncReinit = 2'd2,
    FuncSeq    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StsOk      = 2'd0,
    StsNoSpace = 2'd1,
    StsZero    = 2'd2,
    StsIgnored = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SegFree   = 2'd0,
    SegOpen   = 2'd1,
    SegSealed = 2'd2
  } seg_state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] payload_bytes;
    logic [15:0] note_segment;
    logic [15:0] note_block;
    logic [16:0] note_count;
    logic [63:0] note_seq;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  seg_out;
    logic [15:0] block_out;
    logic [16:0] count_out;
    logic [63:0] seq_out;
  } out_t;

  // One segment table entry
  typedef struct packed {
    logic [1:0]  state;
    logic [16:0] offset;
  } seg_entry_t;

  // Write request into the segment table
  typedef struct packed {
    logic       we;
    seg_entry_t data;
  } seg_wr_t;

endpackage

`default_nettype wire

### rtl/lsba_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module lsba_div
  import lsba_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DivW-1:0]  dividend_i,
  input  wire logic [DvsrW-1:0] divisor_i,
  output logic                  done_o,
  output logic [DivW-1:0]       quot_o,
  output logic                  rem_nz_o
);

  localparam int unsigned CntW = $clog2(DivW);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DivW-1:0]  quot_q, quot_d;
  logic [DvsrW:0]   rem_q, rem_d;
  logic [DvsrW-1:0] dvsr_q, dvsr_d;
  logic [DvsrW:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem_q[DvsrW-1:0], quot_q[DivW-1]};
  assign fits  = trial >= {1'b0, dvsr_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvsr_d = divisor_i;
    end else if (run_q) begin
      rem_d  = fits ? trial - {1'b0, dvsr_q} : trial;
      quot_d = {quot_q[DivW-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign done_o   = done_q;
  assign quot_o   = quot_q;
  assign rem_nz_o = |rem_q;

endmodule

`default_nettype wire

### rtl/lsba_seg_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Segment table: one write port, one registered read port
module lsba_seg_mem
  import lsba_pkg::*;
#(
  parameter int unsigned Depth = MaxSegmentsDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire seg_wr_t          wr_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output seg_entry_t            rdata_o
);

  seg_entry_t mem_q [Depth];
  seg_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[waddr_i] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/log_segment_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Allocate runs the divider for the block count; a zero or oversize request answers then;
//   one fitting the open active segment updates it, else a lowest-free search checks
//   segments in turn, sealing an active one that is too full. Note reads and writes its
//   segment; an ignored note and sequence answer directly; reinit clears every entry.
// Throughput: one item at a time; the next is taken once the result sits in the output register.
// Reset: registers take reset values, then all MaxSegments entries clear with input stalled.
module log_segment_block_allocator
  import lsba_pkg::*;
#(
  parameter int unsigned MaxSegments = MaxSegmentsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire in_t         in_data_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output out_t             out_data_o,
  input  wire logic        out_stall_i,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned IdxW = $clog2(MaxSegments);
  localparam int unsigned SegW = $clog2(MaxSegments + 1);
  localparam int unsigned SegsRst = (MaxSegments < 256) ? MaxSegments : 256;

  typedef enum logic [9:0] {
    StIdle    = 10'b0000000001,
    StClear   = 10'b0000000010,
    StDiv     = 10'b0000000100,
    StActRd   = 10'b0000001000,
    StActChk  = 10'b0000010000,
    StScanRd  = 10'b0000100000,
    StScanChk = 10'b0001000000,
    StNoteRd  = 10'b0010000000,
    StNoteChk = 10'b0100000000,
    StResp    = 10'b1000000000
  } state_e;

  // Configuration registers
  logic [8:0]  seg_total_q;
  logic [16:0] seg_blocks_q;
  logic [15:0] reserved_q;
  logic [16:0] block_bytes_q;
  logic [12:0] overhead_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_total_q   <= SegmentTotalRst;
      seg_blocks_q  <= SegmentBlocksRst;
      reserved_q    <= ReservedRst;
      block_bytes_q <= BlockBytesRst;
      overhead_q    <= OverheadRst;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        RegSegmentTotal:  seg_total_q   <= pwdata[8:0];
        RegSegmentBlocks: seg_blocks_q  <= pwdata[16:0];
        RegReserved:      reserved_q    <= pwdata[15:0];
        RegBlockBytes:    block_bytes_q <= pwdata[16:0];
        RegOverhead:      overhead_q    <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegSegmentTotal:  prdata = 32'(seg_total_q);
      RegSegmentBlocks: prdata = 32'(seg_blocks_q);
      RegReserved:      prdata = 32'(reserved_q);
      RegBlockBytes:    prdata = 32'(block_bytes_q);
      RegOverhead:      prdata = 32'(overhead_q);
      default:          prdata = '0;
    endcase
  end

  // Derived segment geometry
  logic [16:0] seg_size, start_off, cap;
  logic [SegW-1:0] segs_lim;

  assign seg_size  = (seg_blocks_q > SegSizeMax) ? SegSizeMax : seg_blocks_q;
  assign start_off = ({1'b0, reserved_q} > seg_size) ? seg_size : {1'b0, reserved_q};
  assign cap       = (seg_size > {1'b0, reserved_q}) ? seg_size - {1'b0, reserved_q} : '0;
  assign segs_lim  = (32'(seg_total_q) < 32'(MaxSegments)) ? SegW'(seg_total_q)
                                                          : SegW'(MaxSegments);

  // Sequencer state
  state_e          state_q, state_d;
  in_t             item_q, item_d;
  logic [DivW-1:0] need_q, need_d;
  out_t            res_q, res_d;
  logic [SegW-1:0] scan_q, scan_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic            clr_resp_q, clr_resp_d;
  logic [SegW-1:0] segs_q, segs_d;
  logic [IdxW-1:0] act_q, act_d;
  logic            actv_q, actv_d;
  logic [63:0]     rsc_q, rsc_d;
  out_t            out_q, out_d;
  logic            outv_q, outv_d;

  // Divider for the block count
  logic            div_start, div_done, div_rem_nz;
  logic [DivW-1:0] div_quot, need_c;
  logic [16:0]     div_dvsr;

  assign div_dvsr = (block_bytes_q == '0) ? 17'd1 : block_bytes_q;
  assign need_c   = div_quot + DivW'(div_rem_nz);

  lsba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DivW'(overhead_q) + DivW'(in_data_i.payload_bytes)),
    .divisor_i  (div_dvsr),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_nz_o   (div_rem_nz)
  );

  // Segment table
  seg_wr_t         mem_wr;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  seg_entry_t      mem_rdata;

  lsba_seg_mem #(
    .Depth (MaxSegments),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .waddr_i (mem_waddr),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Offset arithmetic on the entry just read
  logic [16:0] need17;
  logic [17:0] act_sum, note_end, note_max, note_off;
  logic [63:0] note_seq1;
  logic        note_bad;

  assign need17    = need_q[16:0];
  assign act_sum   = 18'(mem_rdata.offset) + 18'(need17);
  assign note_end  = 18'(item_q.note_block) + 18'(item_q.note_count);
  assign note_max  = (note_end > 18'(mem_rdata.offset)) ? note_end : 18'(mem_rdata.offset);
  assign note_off  = (note_max > 18'(seg_size)) ? 18'(seg_size) : note_max;
  assign note_seq1 = item_q.note_seq + 64'd1;
  assign note_bad  = (32'(in_data_i.note_segment) >= 32'(segs_q)) ||
                     (in_data_i.note_count == '0);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    need_d     = need_q;
    res_d      = res_q;
    scan_d     = scan_q;
    clr_d      = clr_q;
    clr_resp_d = clr_resp_q;
    segs_d     = segs_q;
    act_d      = act_q;
    actv_d     = actv_q;
    rsc_d      = rsc_q;
    out_d      = out_q;
    outv_d     = outv_q & out_stall_i;
    mem_wr     = '0;
    mem_waddr  = act_q;
    mem_raddr  = act_q;
    div_start  = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          res_d  = '0;
          case (in_data_i.func)
            FuncAlloc: begin
              div_start = 1'b1;
              state_d   = StDiv;
            end
            FuncNote: begin
              if (note_bad) begin
                res_d.status = StsIgnored;
                state_d      = StResp;
              end else begin
                state_d = StNoteRd;
              end
            end
            FuncReinit: begin
              clr_d      = '0;
              clr_resp_d = 1'b1;
              segs_d     = segs_lim;
              act_d      = '0;
              actv_d     = 1'b0;
              rsc_d      = 64'd1;
              state_d    = StClear;
            end
            default: begin
              res_d.seq_out = rsc_q;
              rsc_d         = rsc_q + 64'd1;
              state_d       = StResp;
            end
          endcase
        end
      end

      // One entry per cycle back to free
      StClear: begin
        mem_wr.we         = 1'b1;
        mem_wr.data.state = SegFree;
        mem_wr.data.offset = start_off;
        mem_waddr         = clr_q;
        clr_d             = clr_q + 1'b1;
        if (clr_q == IdxW'(MaxSegments - 1)) begin
          state_d = clr_resp_q ? StResp : StIdle;
        end
      end

      StDiv: begin
        if (div_done) begin
          need_d = need_c;
          if (need_c == '0) begin
            res_d.status = StsZero;
            state_d      = StResp;
          end else if (need_c > DivW'(cap)) begin
            res_d.status = StsNoSpace;
            state_d      = StResp;
          end else if (actv_q) begin
            state_d = StActRd;
          end else begin
            scan_d  = '0;
            state_d = StScanRd;
          end
        end
      end

      StActRd: begin
        mem_raddr = act_q;
        state_d   = StActChk;
      end

      // Place in the active segment if open, or seal it when the request does not fit
      StActChk: begin
        mem_waddr = act_q;
        scan_d    = '0;
        if (mem_rdata.state == SegOpen) begin
          mem_wr.we = 1'b1;
          if (act_sum > 18'(seg_size)) begin
            mem_wr.data.state  = SegSealed;
            mem_wr.data.offset = mem_rdata.offset;
            actv_d             = 1'b0;
            state_d            = StScanRd;
          end else begin
            mem_wr.data.state  = SegOpen;
            mem_wr.data.offset = act_sum[16:0];
            res_d.seg_out      = 8'(act_q);
            res_d.block_out    = mem_rdata.offset[15:0];
            res_d.count_out    = need17;
            state_d            = StResp;
          end
        end else begin
          state_d = StScanRd;
        end
      end

      // Lowest-free search
      StScanRd: begin
        mem_raddr = scan_q[IdxW-1:0];
        if (scan_q >= segs_q) begin
          res_d.status = StsNoSpace;
          state_d      = StResp;
        end else begin
          state_d = StScanChk;
        end
      end

      StScanChk: begin
        mem_waddr = scan_q[IdxW-1:0];
        if (mem_rdata.state == SegFree) begin
          mem_wr.we          = 1'b1;
          mem_wr.data.state  = SegOpen;
          mem_wr.data.offset = start_off + need17;
          act_d              = scan_q[IdxW-1:0];
          actv_d             = 1'b1;
          res_d.seg_out      = 8'(scan_q);
          res_d.block_out    = start_off[15:0];
          res_d.count_out    = need17;
          state_d            = StResp;
        end else begin
          scan_d  = scan_q + 1'b1;
          state_d = StScanRd;
        end
      end

      StNoteRd: begin
        mem_raddr = IdxW'(item_q.note_segment);
        state_d   = StNoteChk;
      end

      // Extend the noted segment and make it active
      StNoteChk: begin
        mem_waddr          = IdxW'(item_q.note_segment);
        mem_wr.we          = 1'b1;
        mem_wr.data.state  = (mem_rdata.state == SegFree) ? SegOpen : mem_rdata.state;
        mem_wr.data.offset = note_off[16:0];
        if (note_seq1 > rsc_q) begin
          rsc_d = note_seq1;
        end
        act_d   = IdxW'(item_q.note_segment);
        actv_d  = 1'b1;
        state_d = StResp;
      end

      StResp: begin
        if (!outv_q || !out_stall_i) begin
          out_d   = res_q;
          outv_d  = 1'b1;
          state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_q      <= '0;
      clr_resp_q <= 1'b0;
      segs_q     <= SegW'(SegsRst);
      act_q      <= '0;
      actv_q     <= 1'b0;
      rsc_q      <= 64'd1;
      outv_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      clr_resp_q <= clr_resp_d;
      segs_q     <= segs_d;
      act_q      <= act_d;
      actv_q     <= actv_d;
      rsc_q      <= rsc_d;
      outv_q     <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    need_q <= need_d;
    res_q  <= res_d;
    scan_q <= scan_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = outv_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/lsba_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lsba_checker
  import lsba_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire out_t out_data_o,
  input wire logic out_stall_i
);

  // A result waiting under stall stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Only one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  // A failed allocation reports no placement
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StsNoSpace || out_data_o.status == StsZero) |->
    out_data_o.seg_out == '0 && out_data_o.block_out == '0 && out_data_o.count_out == '0)
    else $error("placement on failed allocation");

  // An ignored note carries no sequence number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StsIgnored |-> out_data_o.seq_out == '0)
    else $error("sequence on ignored note");

endmodule

bind log_segment_block_allocator lsba_checker u_lsba_checker (.*);

`default_nettype wire
